@@ src/cbsp_pkg.sv @@
package cbsp_pkg;

	localparam int CBSP_KEY_BYTES = 32;
	localparam logic [7:0] CBSP_VERSION_RESET = 8'h01;

	localparam logic [3:0] PH_VER    = 4'd0;
	localparam logic [3:0] PH_IDKEY  = 4'd1;
	localparam logic [3:0] PH_SPKID  = 4'd2;
	localparam logic [3:0] PH_SPK    = 4'd3;
	localparam logic [3:0] PH_COUNT  = 4'd4;
	localparam logic [3:0] PH_OPKID  = 4'd5;
	localparam logic [3:0] PH_OPK    = 4'd6;
	localparam logic [3:0] PH_FPRLEN = 4'd7;
	localparam logic [3:0] PH_FPR    = 4'd8;
	localparam logic [3:0] PH_SIGLEN = 4'd9;
	localparam logic [3:0] PH_SIG    = 4'd10;
	localparam logic [3:0] PH_DONE   = 4'd11;

	localparam logic [2:0] ST_BUSY      = 3'd0;
	localparam logic [2:0] ST_COMPLETE  = 3'd1;
	localparam logic [2:0] ST_TRAILING  = 3'd2;
	localparam logic [2:0] ST_BAD_VER   = 3'd3;
	localparam logic [2:0] ST_TRUNCATED = 3'd4;
	localparam logic [2:0] ST_DISCARDED = 3'd5;

	localparam logic CFG_IDX_VERSION = 1'b0;

	typedef struct packed {
		logic [3:0]  field_kind;
		logic [7:0]  byte_value;
		logic [31:0] offset_in_field;
		logic [15:0] entry_number;
		logic [31:0] number_value;
		logic        number_ready;
		logic [2:0]  status;
	} res_t;

endpackage

@@ src/cbsp_apb_regs.sv @@
module cbsp_apb_regs import cbsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  expected_version
);

	logic [7:0] version_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= CBSP_VERSION_RESET;
		end else if (psel && penable && pwrite && paddr[2] == CFG_IDX_VERSION) begin
			version_q <= pwdata[7:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == CFG_IDX_VERSION) ? {24'd0, version_q} : 32'd0;
	assign expected_version = version_q;

endmodule

@@ src/cbsp_parse_core.sv @@
module cbsp_parse_core import cbsp_pkg::*; #(
	parameter int KEY_BYTES = CBSP_KEY_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] data_byte,
	input  logic       end_of_stream,
	input  logic [7:0] expected_version,
	output res_t       res
);

	localparam logic [31:0] KEY_LAST = 32'(KEY_BYTES - 1);

	logic [3:0]  phase_q;
	logic [31:0] pos_q;
	logic [31:0] flen_q;
	logic [31:0] acc_q;
	logic [15:0] remain_q;
	logic [15:0] entry_q;
	logic        err_q;

	logic [3:0]  phase_d;
	logic [31:0] pos_d;
	logic [31:0] flen_d;
	logic [31:0] acc_d;
	logic [15:0] remain_d;
	logic [15:0] entry_d;
	logic        err_d;

	logic [31:0] acc_new;
	logic [31:0] len_last;
	logic [15:0] remain_dec;
	logic        is_last;
	logic        is_num;
	logic        complete;

	always_comb begin
		acc_new = (pos_q == 32'd0) ? {24'd0, data_byte} : {acc_q[23:0], data_byte};
		case (phase_q)
			PH_VER:                   len_last = 32'd0;
			PH_IDKEY, PH_SPK, PH_OPK: len_last = KEY_LAST;
			PH_SPKID, PH_OPKID, PH_SIGLEN: len_last = 32'd3;
			PH_COUNT, PH_FPRLEN:      len_last = 32'd1;
			default:                  len_last = flen_q - 32'd1;
		endcase
		is_last = (pos_q == len_last);
		is_num = (phase_q == PH_SPKID) || (phase_q == PH_COUNT) || (phase_q == PH_OPKID)
			|| (phase_q == PH_FPRLEN) || (phase_q == PH_SIGLEN);
		remain_dec = remain_q - 16'd1;

		phase_d = phase_q;
		pos_d = pos_q;
		flen_d = flen_q;
		acc_d = acc_q;
		remain_d = remain_q;
		entry_d = entry_q;
		err_d = err_q;
		complete = 1'b0;

		res.field_kind = phase_q;
		res.byte_value = data_byte;
		res.offset_in_field = pos_q;
		res.entry_number = 16'd0;
		res.number_value = 32'd0;
		res.number_ready = 1'b0;
		res.status = ST_BUSY;

		if (err_q) begin
			res.field_kind = PH_DONE;
			res.status = ST_DISCARDED;
			pos_d = pos_q + 32'd1;
		end else if (phase_q >= PH_DONE) begin
			res.field_kind = PH_DONE;
			res.status = ST_TRAILING;
			pos_d = pos_q + 32'd1;
		end else begin
			if (phase_q == PH_OPKID || phase_q == PH_OPK) begin
				res.entry_number = entry_q;
			end
			acc_d = acc_new;
			if (phase_q == PH_VER && data_byte != expected_version) begin
				err_d = 1'b1;
				res.status = ST_BAD_VER;
				pos_d = 32'd0;
			end else if (is_last) begin
				if (is_num) begin
					res.number_ready = 1'b1;
					res.number_value = acc_new;
				end
				pos_d = 32'd0;
				case (phase_q)
					PH_VER:   phase_d = PH_IDKEY;
					PH_IDKEY: phase_d = PH_SPKID;
					PH_SPKID: phase_d = PH_SPK;
					PH_SPK:   phase_d = PH_COUNT;
					PH_COUNT: begin
						remain_d = acc_new[15:0];
						entry_d = 16'd0;
						phase_d = (acc_new[15:0] != 16'd0) ? PH_OPKID : PH_FPRLEN;
					end
					PH_OPKID: phase_d = PH_OPK;
					PH_OPK: begin
						remain_d = remain_dec;
						if (remain_dec != 16'd0) begin
							entry_d = entry_q + 16'd1;
							phase_d = PH_OPKID;
						end else begin
							entry_d = 16'd0;
							phase_d = PH_FPRLEN;
						end
					end
					PH_FPRLEN: begin
						flen_d = {16'd0, acc_new[15:0]};
						phase_d = (acc_new[15:0] != 16'd0) ? PH_FPR : PH_SIGLEN;
					end
					PH_FPR: phase_d = PH_SIGLEN;
					PH_SIGLEN: begin
						flen_d = acc_new;
						if (acc_new != 32'd0) begin
							phase_d = PH_SIG;
						end else begin
							phase_d = PH_DONE;
							complete = 1'b1;
						end
					end
					default: begin
						phase_d = PH_DONE;
						complete = 1'b1;
					end
				endcase
				if (complete) begin
					res.status = ST_COMPLETE;
				end
			end else begin
				pos_d = pos_q + 32'd1;
			end
		end

		if (end_of_stream) begin
			if (res.status == ST_BUSY) begin
				res.status = ST_TRUNCATED;
			end
			phase_d = PH_VER;
			pos_d = 32'd0;
			flen_d = 32'd0;
			acc_d = 32'd0;
			remain_d = 16'd0;
			entry_d = 16'd0;
			err_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_VER;
			pos_q <= 32'd0;
			flen_q <= 32'd0;
			acc_q <= 32'd0;
			remain_q <= 16'd0;
			entry_q <= 16'd0;
			err_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			flen_q <= flen_d;
			acc_q <= acc_d;
			remain_q <= remain_d;
			entry_q <= entry_d;
			err_q <= err_d;
		end
	end

	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && end_of_stream) |=> (phase_q == PH_VER && pos_q == 32'd0 && !err_q))
		else $error("state not cleared after end mark");

	a_err_from_version: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(err_q) |-> ($past(phase_q) == PH_VER))
		else $error("error raised outside version byte");

	a_entry_scope: assert property (@(posedge clk) disable iff (!arst_n)
		(entry_q != 16'd0) |-> (phase_q == PH_OPKID || phase_q == PH_OPK))
		else $error("entry index left over outside prekey entries");

	a_num_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res.number_ready |-> (!err_q && is_num && is_last))
		else $error("number reported off a numeric field end");

endmodule

@@ src/contact_bundle_stream_parser.sv @@
// channel  dir  handshake          tdata                              tuser
// s_*      in   s_tvalid/s_tready  [7:0] data_byte                    -, tlast end_of_stream
// m_*      out  m_tvalid/m_tready  byte, offset, entry, number        kind, number_ready, status
// apb      in   psel/penable       expected_version at byte address 0
//
// one beat per cycle sustained while m_tready is high; a byte passes from input to output
// through the input register and then the result register around the parser
// the parser state (phase, counters, accumulator) updates once per byte
// arst_n clears valids, parser state and expected_version (back to 1)
// the input register keeps accepting while a result waits, as long as the result
// register can move; a stalled m side holds the result register and a full input register
module contact_bundle_stream_parser import cbsp_pkg::*; #(
	parameter int KEY_BYTES = CBSP_KEY_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // [7:0] byte_value, [39:8] offset_in_field,
	                               // [55:40] entry_number, [87:56] number_value
	output logic [7:0]  m_tuser,   // [3:0] field_kind, [4] number_ready, [7:5] status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;
	logic       valid_s2;
	res_t       res_s2;
	res_t       res;
	logic       adv;
	logic       fire;
	logic [7:0] expected_version;

	assign adv = !valid_s2 || m_tready;
	assign fire = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	cbsp_apb_regs u_regs (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.expected_version (expected_version)
	);

	cbsp_parse_core #(
		.KEY_BYTES (KEY_BYTES)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (fire),
		.data_byte        (byte_s1),
		.end_of_stream    (eos_s1),
		.expected_version (expected_version),
		.res              (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eos_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {res_s2.number_value, res_s2.entry_number, res_s2.offset_in_field,
		res_s2.byte_value};
	assign m_tuser = {res_s2.status, res_s2.number_ready, res_s2.field_kind};

endmodule
